@@ rtl/grid_raycast_column_defines.svh @@
// ---------------------------------------------------------------------------
// Ray caster assertion macros
// Shared concurrent assertion forms for the column ray caster.
// ---------------------------------------------------------------------------
`ifndef GRID_RAYCAST_COLUMN_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GRC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GRC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/grc_pkg.sv @@
// ---------------------------------------------------------------------------
// grc_pkg
// Widths, register indexes and unit interface types of the column ray caster.
// ---------------------------------------------------------------------------
package grc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAP_DIM_DEF = 32;

  localparam int POS_W = 21;
  localparam int VEC_W = 18;
  localparam int SCR_W = 13;
  localparam int COL_W = 12;
  localparam int CAM_W = 31;
  localparam int RAY_W = 34;
  localparam int DD_W  = 34;
  localparam int SD_W  = 48;
  localparam int DIV_W = 48;
  localparam int CFG_W = 21;

  localparam logic [DD_W-1:0] DELTA_SAT = DD_W'(64'd1 << (2 * FRAC_BITS + 1));

  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5,
    CFG_SCR_W   = 3'd6,
    CFG_SCR_H   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ rtl/grc_ram.sv @@
// ---------------------------------------------------------------------------
// grc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/grc_div.sv @@
// ---------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module grc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grc_pkg::div_req_t  req_i,
  output grc_pkg::div_rsp_t  rsp_o
);

  localparam int W   = grc_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     quo_q, rem_q, den_q;
  logic [W:0]       shl, diff;
  logic             ge;

  always_comb begin
    shl  = {rem_q, quo_q[W-1]};
    diff = shl - {1'b0, den_q};
    ge   = ~diff[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
        quo_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
      end else if (busy_q) begin
        // shift one dividend bit in, subtract where it fits
        rem_q <= ge ? diff[W-1:0] : shl[W-1:0];
        quo_q <= {quo_q[W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ rtl/grid_raycast_column.sv @@
// ---------------------------------------------------------------------------
// grid_raycast_column
// DDA ray caster: holds a square cell map and casts one screen column per item.
// ---------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, func, column, cell | input
//  out      | out_valid_o/out_ready_i, slice, hit cell  | output
//  cfg      | cfg_we_i, cfg_idx_i, cfg_data_i           | input
//
//  A map write lands in the cycle it is accepted. A cast takes an accept
//  step, up to five divisions on the shared 48-bit restoring divider (launch,
//  48 quotient bits, done), the multiplier steps, a step and then a map read
//  per grid cell walked (a step off the map skips the read) and a load of the
//  output register. A zero ray component skips its division.
//  No clearing pass after reset: the map is undefined until written.
//  A finished result waits in the output register; a new item is taken
//  meanwhile, but the next cast stalls at its end until the output frees.
// ---------------------------------------------------------------------------
`include "grid_raycast_column_defines.svh"

module grid_raycast_column #(
  parameter int MAP_DIM = grc_pkg::MAP_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [grc_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [11:0]                column_i,
  input  logic [4:0]                 cell_x_i,
  input  logic [4:0]                 cell_y_i,
  input  logic [7:0]                 cell_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [11:0]                out_column_o,
  output logic [11:0]                draw_start_o,
  output logic [11:0]                draw_end_o,
  output logic [4:0]                 hit_x_o,
  output logic [4:0]                 hit_y_o,
  output logic [7:0]                 hit_value_o,
  output logic                       hit_side_o
);

  localparam int F     = grc_pkg::FRAC_BITS;
  localparam int IW    = $clog2(MAP_DIM);
  localparam int AW    = $clog2(MAP_DIM * MAP_DIM);
  localparam int MX_W  = ((IW > 5) ? IW : 5) + 2;
  localparam int NUM_W = MX_W + F + 2;
  localparam int LIMIT = 4 * MAP_DIM + 8;
  localparam int CNT_W = $clog2(LIMIT + 1);
  localparam int RW    = grc_pkg::RAY_W;
  localparam int DW    = grc_pkg::DD_W;
  localparam int SW    = grc_pkg::SD_W;
  localparam int QW    = grc_pkg::DIV_W;
  localparam int CW    = grc_pkg::CAM_W;
  localparam int VW    = grc_pkg::VEC_W;
  localparam int PW    = VW + CW;
  localparam logic signed [MX_W-1:0] DIM_S = MX_W'(MAP_DIM);

  typedef enum logic [4:0] {
    S_IDLE, S_CAM, S_CAMW, S_PX, S_PY, S_RY, S_DX, S_DXW, S_DY, S_DYW,
    S_FX1, S_FX2, S_FX3, S_FY1, S_FY2, S_FY3, S_STEP, S_CHECK,
    S_PERP, S_PERPW, S_LH, S_LHW, S_OUT
  } state_e;

  // ---- configuration registers ----
  logic [grc_pkg::POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [VW-1:0]      dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [grc_pkg::SCR_W-1:0] scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      dir_x_q   <= -VW'(65536);
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= VW'(43254);
      scr_w_q   <= grc_pkg::SCR_W'(640);
      scr_h_q   <= grc_pkg::SCR_W'(480);
    end else if (cfg_we_i) begin
      case (grc_pkg::cfg_idx_e'(cfg_idx_i))
        grc_pkg::CFG_POS_X:   pos_x_q   <= cfg_data_i;
        grc_pkg::CFG_POS_Y:   pos_y_q   <= cfg_data_i;
        grc_pkg::CFG_DIR_X:   dir_x_q   <= cfg_data_i[VW-1:0];
        grc_pkg::CFG_DIR_Y:   dir_y_q   <= cfg_data_i[VW-1:0];
        grc_pkg::CFG_PLANE_X: plane_x_q <= cfg_data_i[VW-1:0];
        grc_pkg::CFG_PLANE_Y: plane_y_q <= cfg_data_i[VW-1:0];
        grc_pkg::CFG_SCR_W:   scr_w_q   <= cfg_data_i[grc_pkg::SCR_W-1:0];
        grc_pkg::CFG_SCR_H:   scr_h_q   <= cfg_data_i[grc_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero screen size acts as one
  logic [grc_pkg::SCR_W-1:0] w_eff, h_eff;
  assign w_eff = (scr_w_q == '0) ? grc_pkg::SCR_W'(1) : scr_w_q;
  assign h_eff = (scr_h_q == '0) ? grc_pkg::SCR_W'(1) : scr_h_q;

  // ---- cast state ----
  state_e               state_q;
  logic [11:0]          col_q;
  logic                 cam_neg_q;
  logic signed [CW-1:0] cam_q;
  logic signed [RW-1:0] rx_q, ry_q;
  logic [DW-1:0]        ddx_q, ddy_q;
  logic [SW-1:0]        sdx_q, sdy_q;
  logic signed [MX_W-1:0] mx_q, my_q;
  logic                 side_q;
  logic [7:0]           hv_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [QW-1:0]        perp_q;
  logic [11:0]          ds_q, de_q;
  logic signed [PW-1:0] prod_q;

  // output register
  logic        out_valid_q;
  logic [11:0] o_col_q, o_ds_q, o_de_q;
  logic [4:0]  o_hx_q, o_hy_q;
  logic [7:0]  o_hv_q;
  logic        o_side_q;

  // ---- shared units ----
  grc_pkg::div_req_t div_req;
  grc_pkg::div_rsp_t div_rsp;

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  logic [7:0]    map_rdata;

  grc_ram #(.WIDTH(8), .DEPTH(MAP_DIM * MAP_DIM)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (cell_value_i),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // write a cell; drop writes outside the map
  assign map_we = in_valid_i && in_ready_o && !func_i &&
                  (32'(cell_x_i) < 32'(MAP_DIM)) && (32'(cell_y_i) < 32'(MAP_DIM));
  assign map_waddr = AW'(cell_x_i) * AW'(MAP_DIM) + AW'(cell_y_i);

  function automatic logic [11:0] sat12(input logic signed [33:0] v);
    if (v < 0) begin
      return 12'd0;
    end
    return (v > 34'sd4095) ? 12'd4095 : v[11:0];
  endfunction

  // ---- combinational helpers ----
  logic signed [14:0]   cam_sn;
  logic [13:0]          cam_mag;
  logic [CW-1:0]        cam_uq;
  logic [RW-1:0]        rx_abs, ry_abs;
  logic [F:0]           fx, fy;
  logic signed [VW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [PW-1:0] psh;
  logic                 take_x;
  logic signed [MX_W-1:0] mx_n, my_n;
  logic [SW-1:0]        sdx_n, sdy_n;
  logic                 edge_n;
  logic signed [MX_W-1:0] m_sel;
  logic signed [NUM_W-1:0] num_s, num_abs;
  logic [RW-1:0]        ray_abs;
  logic [32:0]          lh_h, h_h, de_u;
  logic signed [33:0]   ds_s, de_s, full_de;
  logic signed [MX_W-1:0] cx_cl, cy_cl;

  always_comb begin
    cam_sn  = $signed({2'b00, col_q, 1'b0}) - $signed({2'b00, w_eff});
    cam_mag = cam_sn[14] ? 14'(-cam_sn) : cam_sn[13:0];
    cam_uq  = CW'(div_rsp.quo[CW-1:0] + QW'(div_rsp.rem != '0));

    rx_abs = rx_q[RW-1] ? RW'(-rx_q) : RW'(rx_q);
    ry_abs = ry_q[RW-1] ? RW'(-ry_q) : RW'(ry_q);
    fx = rx_q[RW-1] ? {1'b0, pos_x_q[F-1:0]} : ((F+1)'(1) << F) - {1'b0, pos_x_q[F-1:0]};
    fy = ry_q[RW-1] ? {1'b0, pos_y_q[F-1:0]} : ((F+1)'(1) << F) - {1'b0, pos_y_q[F-1:0]};

    // operand select for the shared multiplier
    case (state_q)
      S_PX:    begin mul_a = plane_x_q;          mul_b = cam_q; end
      S_PY:    begin mul_a = plane_y_q;          mul_b = cam_q; end
      S_FX1:   begin mul_a = VW'(fx); mul_b = CW'(ddx_q[DW-1:F]); end
      S_FX2:   begin mul_a = VW'(fx); mul_b = CW'(ddx_q[F-1:0]);  end
      S_FY1:   begin mul_a = VW'(fy); mul_b = CW'(ddy_q[DW-1:F]); end
      S_FY2:   begin mul_a = VW'(fy); mul_b = CW'(ddy_q[F-1:0]);  end
      default: begin mul_a = '0;               mul_b = '0;    end
    endcase
    psh = prod_q >>> F;

    // one DDA step: advance along the nearer grid line
    take_x = sdx_q < sdy_q;
    mx_n   = mx_q;
    my_n   = my_q;
    sdx_n  = sdx_q;
    sdy_n  = sdy_q;
    if (take_x) begin
      sdx_n = sdx_q + SW'(ddx_q);
      mx_n  = rx_q[RW-1] ? mx_q - 1'b1 : mx_q + 1'b1;
    end else begin
      sdy_n = sdy_q + SW'(ddy_q);
      my_n  = ry_q[RW-1] ? my_q - 1'b1 : my_q + 1'b1;
    end
    edge_n = (mx_n < 0) || (mx_n >= DIM_S) || (my_n < 0) || (my_n >= DIM_S);
    map_raddr = AW'(mx_n[IW-1:0]) * AW'(MAP_DIM) + AW'(my_n[IW-1:0]);

    // perpendicular distance numerator
    if (side_q) begin
      m_sel   = my_q + MX_W'(ry_q[RW-1]);
      ray_abs = ry_abs;
      num_s   = (NUM_W'(m_sel) <<< F) - $signed(NUM_W'(pos_y_q));
    end else begin
      m_sel   = mx_q + MX_W'(rx_q[RW-1]);
      ray_abs = rx_abs;
      num_s   = (NUM_W'(m_sel) <<< F) - $signed(NUM_W'(pos_x_q));
    end
    num_abs = (num_s < 0) ? -num_s : num_s;

    // slice ends from line height
    lh_h    = div_rsp.quo[33:1];
    h_h     = 33'(h_eff >> 1);
    ds_s    = $signed({1'b0, h_h}) - $signed({1'b0, lh_h});
    de_u    = lh_h + h_h;
    de_s    = (de_u >= 33'(h_eff)) ? $signed(34'(h_eff) - 34'sd1) : $signed({1'b0, de_u});
    full_de = $signed(34'(h_eff) - 34'sd1);

    cx_cl = (mx_q < 0) ? '0 : ((mx_q >= DIM_S) ? DIM_S - 1'b1 : mx_q);
    cy_cl = (my_q < 0) ? '0 : ((my_q >= DIM_S) ? DIM_S - 1'b1 : my_q);

    // divider requests
    div_req = '0;
    case (state_q)
      S_CAM: begin
        div_req.start = 1'b1;
        div_req.num   = QW'(cam_mag) << F;
        div_req.den   = QW'(w_eff);
      end
      S_DX: begin
        div_req.start = (rx_abs != '0);
        div_req.num   = QW'(1) << (2 * F);
        div_req.den   = QW'(rx_abs);
      end
      S_DY: begin
        div_req.start = (ry_abs != '0);
        div_req.num   = QW'(1) << (2 * F);
        div_req.den   = QW'(ry_abs);
      end
      S_PERP: begin
        div_req.start = (ray_abs != '0);
        div_req.num   = QW'(num_abs) << F;
        div_req.den   = QW'(ray_abs);
      end
      S_LH: begin
        div_req.start = 1'b1;
        div_req.num   = QW'(h_eff) << F;
        div_req.den   = perp_q;
      end
      default: ;
    endcase
  end

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;
      // drop the result once it transfers, unless a new one loads in its place
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && func_i) begin
            col_q   <= column_i;
            state_q <= S_CAM;
          end
        end
        S_CAM: begin
          cam_neg_q <= cam_sn[14];
          state_q   <= S_CAMW;
        end
        S_CAMW: begin
          // floor toward minus infinity on a negative numerator
          if (div_rsp.done) begin
            cam_q   <= cam_neg_q ? -$signed(cam_uq) : $signed(div_rsp.quo[CW-1:0]);
            state_q <= S_PX;
          end
        end
        S_PX: state_q <= S_PY;
        S_PY: begin
          rx_q    <= {{(RW-VW){dir_x_q[VW-1]}}, dir_x_q} + psh[RW-1:0];
          state_q <= S_RY;
        end
        S_RY: begin
          ry_q    <= {{(RW-VW){dir_y_q[VW-1]}}, dir_y_q} + psh[RW-1:0];
          state_q <= S_DX;
        end
        S_DX: begin
          if (rx_abs == '0) begin
            ddx_q   <= grc_pkg::DELTA_SAT;
            state_q <= S_DY;
          end else begin
            state_q <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_rsp.done) begin
            ddx_q   <= div_rsp.quo[DW-1:0];
            state_q <= S_DY;
          end
        end
        S_DY: begin
          if (ry_abs == '0) begin
            ddy_q   <= grc_pkg::DELTA_SAT;
            state_q <= S_FX1;
          end else begin
            state_q <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_rsp.done) begin
            ddy_q   <= div_rsp.quo[DW-1:0];
            state_q <= S_FX1;
          end
        end
        S_FX1: state_q <= S_FX2;
        S_FX2: begin
          sdx_q   <= SW'(prod_q);
          state_q <= S_FX3;
        end
        S_FX3: begin
          sdx_q   <= sdx_q + SW'(psh);
          state_q <= S_FY1;
        end
        S_FY1: state_q <= S_FY2;
        S_FY2: begin
          sdy_q   <= SW'(prod_q);
          state_q <= S_FY3;
        end
        S_FY3: begin
          sdy_q   <= sdy_q + SW'(psh);
          mx_q    <= MX_W'(pos_x_q[grc_pkg::POS_W-1:F]);
          my_q    <= MX_W'(pos_y_q[grc_pkg::POS_W-1:F]);
          side_q  <= 1'b0;
          hv_q    <= '0;
          cnt_q   <= '0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          sdx_q  <= sdx_n;
          sdy_q  <= sdy_n;
          mx_q   <= mx_n;
          my_q   <= my_n;
          side_q <= !take_x;
          cnt_q  <= cnt_q + 1'b1;
          if (edge_n) begin
            hv_q    <= '0;
            state_q <= S_PERP;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          hv_q <= map_rdata;
          if (map_rdata != '0 || cnt_q == CNT_W'(LIMIT)) begin
            state_q <= S_PERP;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_PERP: begin
          if (ray_abs == '0) begin
            ds_q    <= '0;
            de_q    <= sat12(full_de);
            state_q <= S_OUT;
          end else begin
            state_q <= S_PERPW;
          end
        end
        S_PERPW: begin
          if (div_rsp.done) begin
            perp_q <= div_rsp.quo;
            if (div_rsp.quo == '0) begin
              ds_q    <= '0;
              de_q    <= sat12(full_de);
              state_q <= S_OUT;
            end else begin
              state_q <= S_LH;
            end
          end
        end
        S_LH: state_q <= S_LHW;
        S_LHW: begin
          if (div_rsp.done) begin
            ds_q    <= sat12(ds_s);
            de_q    <= sat12(de_s);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register frees
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_col_q     <= col_q;
            o_ds_q      <= ds_q;
            o_de_q      <= de_q;
            o_hx_q      <= cx_cl[4:0];
            o_hy_q      <= cy_cl[4:0];
            o_hv_q      <= hv_q;
            o_side_q    <= side_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_column_o = o_col_q;
  assign draw_start_o = o_ds_q;
  assign draw_end_o   = o_de_q;
  assign hit_x_o      = o_hx_q;
  assign hit_y_o      = o_hy_q;
  assign hit_value_o  = o_hv_q;
  assign hit_side_o   = o_side_q;

  // ---- assertions ----
  `GRC_ASSERT_IMP(a_div_idle_start, clk_i, rst_ni, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `GRC_ASSERT_IMP(a_slice_order, clk_i, rst_ni, out_valid_o, draw_start_o <= draw_end_o, "slice start past end")
  `GRC_ASSERT_IMP(a_hit_in_map, clk_i, rst_ni, out_valid_o, 32'(hit_x_o) < 32'(MAP_DIM), "hit index off map")
  `GRC_ASSERT_NXT(a_out_load, clk_i, rst_ni, (state_q == S_OUT) && (!out_valid_q || out_ready_i), out_valid_o && in_ready_o, "result not loaded")

endmodule

@@ tb/tb_grid_raycast_column.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grid_raycast_column
// Self-checking bench for the column ray caster. It clears the map, runs a
// short table of directed items, and then random map writes and casts over
// several camera and screen settings. Every result is checked, against an
// in-bench DDA predictor or the answer typed into its table row.
// ---------------------------------------------------------------------------
module tb_grid_raycast_column;

  localparam longint ONE    = 64'sd65536;
  localparam longint DSAT   = 64'sd1 <<< 33;
  localparam int     DIM    = grc_pkg::MAP_DIM_DEF;
  localparam int     PHASES = 8;
  localparam int     PER_PHASE = 120;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] ds;
    logic [11:0] de;
    logic [4:0]  hx;
    logic [4:0]  hy;
    logic [7:0]  hv;
    logic        side;
  } slice_t;

  typedef struct packed {
    logic        func;
    logic [11:0] column;
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [7:0]  val;
    logic        typed;
    slice_t      exp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [grc_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = 1'b0;
  logic [11:0] column_i = '0;
  logic [4:0]  cell_x_i = '0;
  logic [4:0]  cell_y_i = '0;
  logic [7:0]  cell_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] out_column_o, draw_start_o, draw_end_o;
  logic [4:0]  hit_x_o, hit_y_o;
  logic [7:0]  hit_value_o;
  logic        hit_side_o;

  grid_raycast_column u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the register file (masked raw values) and of the map.
  longint     cam_reg [8];
  logic [7:0] cell_mirror [DIM][DIM];
  slice_t     slice_q [$];
  int         mismatches = 0;
  int         casts_sent = 0, writes_sent = 0, slices_seen = 0;
  bit         long_hold_req = 1'b0;

  function automatic longint sext18(longint v);
    v &= 64'h3FFFF;
    return v[17] ? v - 64'sd262144 : v;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint recip_abs(longint r);
    longint a;
    a = r < 0 ? -r : r;
    return a == 0 ? DSAT : (64'sd1 <<< 32) / a;
  endfunction

  function automatic longint frac_scale(longint f, longint d);
    return f * (d >>> 16) + ((f * (d & (ONE - 1))) >>> 16);
  endfunction

  function automatic longint clamp_cell(longint v);
    return v < 0 ? 0 : (v > DIM - 1 ? DIM - 1 : v);
  endfunction

  function automatic logic [11:0] sat_row(longint v);
    return v < 0 ? 12'd0 : (v > 4095 ? 12'd4095 : v[11:0]);
  endfunction

  // DDA walk of one column against the bench map and registers.
  function automatic slice_t trace_column(logic [11:0] col);
    longint w, h, posx, posy, cam, rx, ry, ddx, ddy, sdx, sdy, mx, my, stx, sty;
    longint num, ray, perp, lh, ds, de;
    int     side, hv;
    bit     edge_hit;
    slice_t r;
    w = cam_reg[grc_pkg::CFG_SCR_W] == 0 ? 1 : cam_reg[grc_pkg::CFG_SCR_W];
    h = cam_reg[grc_pkg::CFG_SCR_H] == 0 ? 1 : cam_reg[grc_pkg::CFG_SCR_H];
    posx = cam_reg[grc_pkg::CFG_POS_X];
    posy = cam_reg[grc_pkg::CFG_POS_Y];
    side = 0;
    hv = 0;
    edge_hit = 1'b0;
    cam = floor_quot((2 * longint'(col) - w) * ONE, w);
    rx = sext18(cam_reg[grc_pkg::CFG_DIR_X]) +
         floor_quot(sext18(cam_reg[grc_pkg::CFG_PLANE_X]) * cam, ONE);
    ry = sext18(cam_reg[grc_pkg::CFG_DIR_Y]) +
         floor_quot(sext18(cam_reg[grc_pkg::CFG_PLANE_Y]) * cam, ONE);
    ddx = recip_abs(rx);
    ddy = recip_abs(ry);
    mx = posx >>> 16;
    my = posy >>> 16;
    if (rx < 0) begin
      stx = -1; sdx = frac_scale(posx & (ONE - 1), ddx);
    end else begin
      stx = 1;  sdx = frac_scale(ONE - (posx & (ONE - 1)), ddx);
    end
    if (ry < 0) begin
      sty = -1; sdy = frac_scale(posy & (ONE - 1), ddy);
    end else begin
      sty = 1;  sdy = frac_scale(ONE - (posy & (ONE - 1)), ddy);
    end
    for (int n = 0; n < 4 * DIM + 8; n++) begin
      if (sdx < sdy) begin
        sdx += ddx; mx += stx; side = 0;
      end else begin
        sdy += ddy; my += sty; side = 1;
      end
      if (mx < 0 || mx >= DIM || my < 0 || my >= DIM) begin
        edge_hit = 1'b1;
        break;
      end
      hv = cell_mirror[mx][my];
      if (hv != 0) break;
    end
    if (edge_hit) hv = 0;
    if (side == 0) begin
      num = (mx + (stx < 0 ? 1 : 0)) * ONE - posx; ray = rx;
    end else begin
      num = (my + (sty < 0 ? 1 : 0)) * ONE - posy; ray = ry;
    end
    if (num < 0) num = -num;
    if (ray < 0) ray = -ray;
    perp = ray == 0 ? 0 : (num * ONE) / ray;
    if (perp <= 0) begin
      ds = 0;
      de = h - 1;
    end else begin
      lh = (h * ONE) / perp;
      ds = h / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = lh / 2 + h / 2;
      if (de >= h) de = h - 1;
    end
    r.column = col;
    r.ds     = sat_row(ds);
    r.de     = sat_row(de);
    r.hx     = 5'(clamp_cell(mx));
    r.hy     = 5'(clamp_cell(my));
    r.hv     = 8'(hv);
    r.side   = 1'(side);
    return r;
  endfunction

  // Register write at the next edge; call only while the block is idle.
  task automatic write_reg(grc_pkg::cfg_idx_e idx, longint v);
    longint masked;
    masked = (idx == grc_pkg::CFG_POS_X || idx == grc_pkg::CFG_POS_Y) ? (v & 64'h1FFFFF) :
             (idx == grc_pkg::CFG_SCR_W || idx == grc_pkg::CFG_SCR_H) ? (v & 64'h1FFF) :
             (v & 64'h3FFFF);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= grc_pkg::CFG_W'(v);
    @(posedge clk_i);
    cam_reg[idx] = masked;
  endtask

  task automatic load_camera(longint px, longint py, longint dx, longint dy,
                             longint plx, longint ply, longint w, longint h);
    write_reg(grc_pkg::CFG_POS_X, px);
    write_reg(grc_pkg::CFG_POS_Y, py);
    write_reg(grc_pkg::CFG_DIR_X, dx);
    write_reg(grc_pkg::CFG_DIR_Y, dy);
    write_reg(grc_pkg::CFG_PLANE_X, plx);
    write_reg(grc_pkg::CFG_PLANE_Y, ply);
    write_reg(grc_pkg::CFG_SCR_W, w);
    write_reg(grc_pkg::CFG_SCR_H, h);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one item, hold it until the transfer, then record what it should cause.
  // Gaps that follow drop valid; back-to-back items keep it high.
  task automatic offer_item(logic func, logic [11:0] col, logic [4:0] cx, logic [4:0] cy,
                            logic [7:0] val, logic typed, slice_t exp, bit idle_after);
    int gap, pick;
    in_valid_i   <= 1'b1;
    func_i       <= func;
    column_i     <= col;
    cell_x_i     <= cx;
    cell_y_i     <= cy;
    cell_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    if (func) begin
      slice_q.push_back(typed ? exp : trace_column(col));
      casts_sent++;
    end else begin
      cell_mirror[cx][cy] = val;
      writes_sent++;
    end
    pick = $urandom_range(0, 99);
    gap = pick < 50 ? 0 : (pick < 90 ? $urandom_range(1, 3) : $urandom_range(10, 60));
    if (idle_after) gap = 0;
    if (gap > 0 || idle_after) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // Drain, then let any trailing map write retire before touching registers.
  task automatic drain_block();
    wait (slice_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic longint rand_vec();
    return sext18(longint'($urandom_range(0, 262143)));
  endfunction

  // Result side: check every transfer, then pick ready for the next edge.
  initial begin : sink
    int     stall;
    slice_t got, want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{out_column_o, draw_start_o, draw_end_o, hit_x_o, hit_y_o, hit_value_o,
                hit_side_o};
        slices_seen++;
        if (slice_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected slice col=%0d", got.column);
        end else begin
          want = slice_q.pop_front();
          if (got.column != want.column || got.ds != want.ds || got.de != want.de ||
              got.hx != want.hx || got.hy != want.hy || got.hv != want.hv ||
              got.side != want.side) begin
            mismatches++;
            if (mismatches <= 10)
              $display("slice mismatch exp col=%0d ds=%0d de=%0d hit=(%0d,%0d) v=%0d s=%0d | got col=%0d ds=%0d de=%0d hit=(%0d,%0d) v=%0d s=%0d",
                       want.column, want.ds, want.de, want.hx, want.hy, want.hv, want.side,
                       got.column, got.ds, got.de, got.hx, got.hy, got.hv, got.side);
          end
        end
      end
      // Long hold-off on request so the block backs up onto its input.
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 4000;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < 30)
          stall = $urandom_range(0, 9) < 9 ? $urandom_range(1, 4) : $urandom_range(20, 120);
      end
    end
  end

  initial begin : watchdog
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Directed rows; only the first cast has its answer typed in: defaults with
  // the camera at the map corner looking down -x hit the edge at once and
  // fill the screen.
  dir_row_t dir_rows [12] = '{
    '{1'b1, 12'd320, 5'd0,  5'd0,  8'd0,   1'b1, '{12'd320, 12'd0, 12'd479, 5'd0, 5'd0, 8'd0, 1'b0}},
    '{1'b0, 12'd0,   5'd31, 5'd31, 8'd255, 1'b0, '0},
    '{1'b0, 12'd0,   5'd0,  5'd0,  8'd1,   1'b0, '0},
    '{1'b0, 12'd0,   5'd0,  5'd5,  8'd128, 1'b0, '0},
    '{1'b0, 12'd0,   5'd1,  5'd0,  8'd127, 1'b0, '0},
    '{1'b1, 12'd0,   5'd0,  5'd0,  8'd0,   1'b0, '0},
    '{1'b1, 12'd639, 5'd0,  5'd0,  8'd0,   1'b0, '0},
    '{1'b1, 12'd640, 5'd0,  5'd0,  8'd0,   1'b0, '0},
    '{1'b1, 12'd4095,5'd0,  5'd0,  8'd0,   1'b0, '0},
    '{1'b1, 12'd1,   5'd0,  5'd0,  8'd0,   1'b0, '0},
    '{1'b0, 12'd0,   5'd1,  5'd0,  8'd0,   1'b0, '0},
    '{1'b1, 12'd500, 5'd0,  5'd0,  8'd0,   1'b0, '0}
  };

  initial begin : stimulus
    int     width, pick;
    logic [11:0] col;
    cam_reg = '{0, 0, 64'h30000, 0, 0, 43254, 640, 480};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Clear every cell so no cast ever reads an unwritten one.
    for (int x = 0; x < DIM; x++)
      for (int y = 0; y < DIM; y++)
        offer_item(1'b0, '0, 5'(x), 5'(y), 8'd0, 1'b0, '0, 1'b0);

    foreach (dir_rows[i])
      offer_item(dir_rows[i].func, dir_rows[i].column, dir_rows[i].cx, dir_rows[i].cy,
                 dir_rows[i].val, dir_rows[i].typed, dir_rows[i].exp, i == 11);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block();
      case (ph)
        0: load_camera(64'h108000, 64'h108000, -65536, 0, 0, 43254, 640, 480);
        1: load_camera(64'h1FFFFF, 64'h1FFFFF, 131071, -131072, -131072, 131071, 4096, 4096);
        2: load_camera(0, 0, 0, 0, 0, 0, 0, 0);
        3: load_camera(64'h0A4000, 64'h150000, 0, 65536, -43254, 0, 1, 1);
        4: load_camera(64'h0C0000, 64'h050000, 46341, 46341, -30000, 30000, 320, 4096);
        default: load_camera($urandom_range(0, 2097151), $urandom_range(0, 2097151),
                             rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                             $urandom_range(1, 4096), $urandom_range(1, 4096));
      endcase
      if (ph == 1) long_hold_req = 1'b1;
      width = cam_reg[grc_pkg::CFG_SCR_W] == 0 ? 1 : int'(cam_reg[grc_pkg::CFG_SCR_W]);
      for (int k = 0; k < PER_PHASE; k++) begin
        // Mid-phase pause until the block has handed back everything.
        if (ph == 0 && k == 60) begin
          in_valid_i <= 1'b0;
          wait (slice_q.size() == 0);
          @(posedge clk_i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          col = $urandom_range(0, 9) == 0 ? 12'($urandom) : 12'($urandom_range(0, width - 1));
          offer_item(1'b1, col, 5'($urandom), 5'($urandom), 8'($urandom), 1'b0, '0,
                     k == PER_PHASE - 1);
        end else begin
          offer_item(1'b0, 12'($urandom), 5'($urandom), 5'($urandom),
                     $urandom_range(0, 9) < 7 ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0, '0,
                     k == PER_PHASE - 1);
        end
      end
    end

    wait (slice_q.size() == 0);
    repeat (800) @(posedge clk_i);
    $display("covered %0d casts and %0d map writes over %0d camera settings",
             casts_sent, writes_sent, PHASES + 1);
    $display("slices checked: %0d, mismatches: %0d", slices_seen, mismatches);
    if (mismatches == 0 && slice_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
